// File: hdl/ptt_pkg.sv
// Shared types and constants of the pending request tag table.
// Used by the channel interfaces, the entry memory, the due unit and the top level.
package ptt_pkg;

    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int TAG_W       = 6;
    localparam int ID_W        = 16;
    localparam int CLI_W       = 16;
    localparam int TIME_W      = 32;
    localparam int RETRY_W     = 4;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_ERASE = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
    localparam logic [OP_W-1:0] OP_SWEEP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RETRY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd6;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY   = 1'd1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5;
    localparam logic [RETRY_W-1:0]   RETRY_RESET   = 4'd2;

    typedef struct packed {
        logic [ID_W-1:0]    request_id;
        logic [CLI_W-1:0]   client;
        logic [TIME_W-1:0]  stamp;
        logic [RETRY_W-1:0] retries;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [ID_W-1:0]     request_id;
        logic [CLI_W-1:0]    client;
        logic [RETRY_W-1:0]  retries;
        logic                last;
    } result_t;

    typedef struct packed {
        logic due;
        logic can_retry;
    } due_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_POP,
        S_POP_DATA,
        S_EMIT,
        S_SW_CHECK,
        S_SW_EVAL,
        S_SW_DONE
    } state_t;

endpackage

// File: hdl/ptt_if.sv
// Valid/ready channel interfaces for requests into and results out of the table.
// Depends on ptt_pkg for field widths.
interface ptt_req_if;
    logic                       valid;
    logic                       ready;
    logic [ptt_pkg::OP_W-1:0]   opcode;
    logic [ptt_pkg::ID_W-1:0]   request_id;
    logic [ptt_pkg::CLI_W-1:0]  client_handle;
    logic [ptt_pkg::TAG_W-1:0]  slot_tag;

    modport source (output valid, opcode, request_id, client_handle, slot_tag, input ready);
    modport sink   (input valid, opcode, request_id, client_handle, slot_tag, output ready);
endinterface

interface ptt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ptt_pkg::STATUS_W-1:0] status;
    logic [ptt_pkg::TAG_W-1:0]    tag_out;
    logic [ptt_pkg::ID_W-1:0]     request_id_out;
    logic [ptt_pkg::CLI_W-1:0]    client_handle_out;
    logic [ptt_pkg::RETRY_W-1:0]  retries_out;
    logic                         last;

    modport source (output valid, status, tag_out, request_id_out, client_handle_out,
                    retries_out, last, input ready);
    modport sink   (input valid, status, tag_out, request_id_out, client_handle_out,
                    retries_out, last, output ready);
endinterface

// File: hdl/ptt_entry_ram.sv
// Entry memory of the tag table: one write port, one read port, registered read data.
// Depends on ptt_pkg for the entry type.
module ptt_entry_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  ptt_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output ptt_pkg::entry_t rdata
);

    ptt_pkg::entry_t mem [DEPTH];
    ptt_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ptt_due_unit.sv
// Age and retry check of one entry: wrapping age subtract with timeout compare.
// Depends on ptt_pkg for widths and the due_t result.
module ptt_due_unit (
    input  logic [ptt_pkg::TIME_W-1:0]    cur_time,
    input  ptt_pkg::entry_t               entry,
    input  logic [ptt_pkg::TIMEOUT_W-1:0] timeout,
    input  logic [ptt_pkg::RETRY_W-1:0]   retry_limit,
    output ptt_pkg::due_t                 result
);

    logic [ptt_pkg::TIME_W-1:0] age;

    // The age wraps modulo the time width, as the seconds counter does.
    assign age = cur_time - entry.stamp;
    assign result.due = age >= {{(ptt_pkg::TIME_W - ptt_pkg::TIMEOUT_W){1'b0}}, timeout};
    assign result.can_retry = entry.retries < retry_limit;

endmodule

// File: hdl/pending_request_tag_table_top.sv
// Top level of the pending request tag table: sequencer, valid bits and output stage.
// Depends on ptt_pkg, ptt_if (ptt_req_if, ptt_rsp_if), ptt_entry_ram and ptt_due_unit.
//
// Usage: requests arrive on the req channel (opcode add, pop, erase, tick, sweep) and
// results leave on the rsp channel, each with a last flag on the final result of a
// request. Configuration (timeout in ticks, retry limit) is written through the plain
// cfg_we / cfg_index / cfg_data port while the block is idle.
// The table takes one request at a time; req.ready is high only while the sequencer
// is idle. Tick and erase complete without leaving the idle state and give no result.
// A pop checks the valid bit of its tag, then reads the entry memory. An add scans
// the valid bits one slot per cycle from the rotating pointer. A sweep visits every
// slot in ascending order; a valid slot needs a memory read, then the age compare in
// the single shared age/retry unit.
// Results go through an output register; a sweep result is held one step back so the
// last flag can be set once the walk ends. When the receiver stalls, the sequencer
// waits with its work and nothing is lost.
// Reset clears all valid bits at once, the time, the pointer and the registers to
// their defaults; the entry memory needs no clearing pass.
module pending_request_tag_table_top #(
    parameter int SLOTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ptt_req_if.sink                           req,
    ptt_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [ptt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_CNT = CW'(SLOTS);
    localparam logic [ptt_pkg::TAG_W:0] SLOTS_EXT = (ptt_pkg::TAG_W + 1)'(SLOTS);

    ptt_pkg::state_t state_reg, state_next;

    logic [SLOTS-1:0]                  valid_reg;
    logic [ptt_pkg::TIME_W-1:0]        time_reg, time_next;
    logic [IW-1:0]                     next_slot_reg, next_slot_next;
    logic [ptt_pkg::TIMEOUT_W-1:0]     timeout_reg;
    logic [ptt_pkg::RETRY_W-1:0]       retry_limit_reg;

    logic [ptt_pkg::ID_W-1:0]          rid_reg;
    logic [ptt_pkg::CLI_W-1:0]         cli_reg;
    logic [ptt_pkg::TAG_W-1:0]         tag_reg;
    logic [IW-1:0]                     idx_reg, idx_next;
    logic [CW-1:0]                     scan_cnt_reg, scan_cnt_next;

    logic                              out_valid_reg;
    ptt_pkg::result_t                  out_reg, out_next;
    logic                              pend_valid_reg, pend_valid_next;
    ptt_pkg::result_t                  pend_reg, pend_next;
    ptt_pkg::result_t                  res_reg, res_next;

    logic                              in_accept;
    logic                              out_free;
    logic                              out_load;
    logic                              pend_load;
    logic                              res_load;
    logic                              valid_set;
    logic                              valid_clr;
    logic [IW-1:0]                     valid_idx;

    logic                              ram_we;
    logic [IW-1:0]                     ram_waddr;
    ptt_pkg::entry_t                   ram_wdata;
    logic                              ram_re;
    logic [IW-1:0]                     ram_raddr;
    ptt_pkg::entry_t                   ram_rdata;
    ptt_pkg::due_t                     due;
    logic [IW-1:0]                     idx_inc;
    logic                              tag_in_range;

    assign req.ready = (state_reg == ptt_pkg::S_IDLE);
    assign in_accept = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign idx_inc   = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign tag_in_range = {1'b0, tag_reg} < SLOTS_EXT;

    ptt_entry_ram #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptt_due_unit u_due (
        .cur_time    (time_reg),
        .entry       (ram_rdata),
        .timeout     (timeout_reg),
        .retry_limit (retry_limit_reg),
        .result      (due)
    );

    // Sequencer: next state and all data path controls.
    always_comb
    begin
        state_next      = state_reg;
        time_next       = time_reg;
        next_slot_next  = next_slot_reg;
        idx_next        = idx_reg;
        scan_cnt_next   = scan_cnt_reg;
        out_load        = 1'b0;
        out_next        = '0;
        pend_load       = 1'b0;
        pend_next       = '0;
        pend_valid_next = pend_valid_reg;
        res_load        = 1'b0;
        res_next        = '0;
        valid_set       = 1'b0;
        valid_clr       = 1'b0;
        valid_idx       = idx_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;

        unique case (state_reg)
            ptt_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    case (req.opcode)
                        ptt_pkg::OP_ADD:
                        begin
                            idx_next      = next_slot_reg;
                            scan_cnt_next = '0;
                            state_next    = ptt_pkg::S_ADD_SCAN;
                        end
                        ptt_pkg::OP_POP:
                        begin
                            state_next = ptt_pkg::S_POP;
                        end
                        ptt_pkg::OP_ERASE:
                        begin
                            if ({1'b0, req.slot_tag} < SLOTS_EXT)
                            begin
                                valid_clr = 1'b1;
                                valid_idx = req.slot_tag[IW-1:0];
                            end
                        end
                        ptt_pkg::OP_TICK:
                        begin
                            time_next = time_reg + 1'b1;
                        end
                        ptt_pkg::OP_SWEEP:
                        begin
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ptt_pkg::S_SW_CHECK;
                        end
                        default:
                        begin
                            state_next = ptt_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            ptt_pkg::S_ADD_SCAN:
            begin
                if (scan_cnt_reg == SLOTS_CNT)
                begin
                    res_load        = 1'b1;
                    res_next.status = ptt_pkg::ST_FULL;
                    state_next      = ptt_pkg::S_EMIT;
                end
                else if (!valid_reg[idx_reg])
                begin
                    valid_set           = 1'b1;
                    ram_we              = 1'b1;
                    ram_wdata.request_id = rid_reg;
                    ram_wdata.client    = cli_reg;
                    ram_wdata.stamp     = time_reg;
                    ram_wdata.retries   = '0;
                    next_slot_next      = idx_inc;
                    res_load            = 1'b1;
                    res_next.status     = ptt_pkg::ST_ADDED;
                    res_next.tag        = ptt_pkg::TAG_W'(idx_reg);
                    res_next.request_id = rid_reg;
                    res_next.client     = cli_reg;
                    state_next          = ptt_pkg::S_EMIT;
                end
                else
                begin
                    idx_next      = idx_inc;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end

            ptt_pkg::S_POP:
            begin
                if (tag_in_range && valid_reg[tag_reg[IW-1:0]])
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = tag_reg[IW-1:0];
                    state_next = ptt_pkg::S_POP_DATA;
                end
                else
                begin
                    res_load        = 1'b1;
                    res_next.status = ptt_pkg::ST_MISSING;
                    res_next.tag    = tag_reg;
                    state_next      = ptt_pkg::S_EMIT;
                end
            end

            ptt_pkg::S_POP_DATA:
            begin
                if (out_free)
                begin
                    out_load            = 1'b1;
                    out_next.status     = ptt_pkg::ST_POPPED;
                    out_next.tag        = tag_reg;
                    out_next.request_id = ram_rdata.request_id;
                    out_next.client     = ram_rdata.client;
                    out_next.retries    = ram_rdata.retries;
                    out_next.last       = 1'b1;
                    valid_clr           = 1'b1;
                    valid_idx           = tag_reg[IW-1:0];
                    state_next          = ptt_pkg::S_IDLE;
                end
            end

            ptt_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_next      = res_reg;
                    out_next.last = 1'b1;
                    state_next    = ptt_pkg::S_IDLE;
                end
            end

            ptt_pkg::S_SW_CHECK:
            begin
                if (valid_reg[idx_reg])
                begin
                    ram_re     = 1'b1;
                    state_next = ptt_pkg::S_SW_EVAL;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ptt_pkg::S_SW_DONE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            ptt_pkg::S_SW_EVAL:
            begin
                if (!due.due)
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_reg == LAST_IDX) ? ptt_pkg::S_SW_DONE
                                                       : ptt_pkg::S_SW_CHECK;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // The held result moves on as a non-final one; this one is held.
                    if (pend_valid_reg)
                    begin
                        out_load      = 1'b1;
                        out_next      = pend_reg;
                        out_next.last = 1'b0;
                    end
                    pend_load           = 1'b1;
                    pend_valid_next     = 1'b1;
                    pend_next.tag       = ptt_pkg::TAG_W'(idx_reg);
                    pend_next.request_id = ram_rdata.request_id;
                    pend_next.client    = ram_rdata.client;
                    if (due.can_retry)
                    begin
                        ram_we             = 1'b1;
                        ram_wdata.stamp    = time_reg;
                        ram_wdata.retries  = ram_rdata.retries + 1'b1;
                        pend_next.status   = ptt_pkg::ST_RETRY;
                        pend_next.retries  = ram_rdata.retries + 1'b1;
                    end
                    else
                    begin
                        valid_clr          = 1'b1;
                        pend_next.status   = ptt_pkg::ST_EXPIRED;
                        pend_next.retries  = ram_rdata.retries;
                    end
                    idx_next   = idx_inc;
                    state_next = (idx_reg == LAST_IDX) ? ptt_pkg::S_SW_DONE
                                                       : ptt_pkg::S_SW_CHECK;
                end
            end

            ptt_pkg::S_SW_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next.status = ptt_pkg::ST_NONE;
                    end
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ptt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ptt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            time_reg        <= '0;
            next_slot_reg   <= '0;
            idx_reg         <= '0;
            scan_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            timeout_reg     <= ptt_pkg::TIMEOUT_RESET;
            retry_limit_reg <= ptt_pkg::RETRY_RESET;
        end
        else
        begin
            if (valid_set)
            begin
                valid_reg[valid_idx] <= 1'b1;
            end
            else if (valid_clr)
            begin
                valid_reg[valid_idx] <= 1'b0;
            end
            time_reg       <= time_next;
            next_slot_reg  <= next_slot_next;
            idx_reg        <= idx_next;
            scan_cnt_reg   <= scan_cnt_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ptt_pkg::CFG_TIMEOUT: timeout_reg     <= cfg_data;
                    ptt_pkg::CFG_RETRY:   retry_limit_reg <= cfg_data[ptt_pkg::RETRY_W-1:0];
                    default:              timeout_reg     <= timeout_reg;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rid_reg <= req.request_id;
            cli_reg <= req.client_handle;
            tag_reg <= req.slot_tag;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
        if (pend_load)
        begin
            pend_reg <= pend_next;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_reg.status;
    assign rsp.tag_out           = out_reg.tag;
    assign rsp.request_id_out    = out_reg.request_id;
    assign rsp.client_handle_out = out_reg.client;
    assign rsp.retries_out       = out_reg.retries;
    assign rsp.last              = out_reg.last;

`ifndef SYNTHESIS
    // A sweep result is only ever held while a sweep is running.
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptt_pkg::S_IDLE) |-> !pend_valid_reg)
        else $error("held sweep result outside a sweep");

    // The output register is never overwritten while a result waits in it.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register loaded while stalled");

    // An add only ever claims a free slot.
    a_set_free: assert property (@(posedge clk) disable iff (!rst_n)
        valid_set |-> !valid_reg[valid_idx])
        else $error("add claimed a slot already in use");

    // The add scan visits each slot at most once.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptt_pkg::S_ADD_SCAN) |-> (scan_cnt_reg <= SLOTS_CNT))
        else $error("add scan ran past the table");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for the pending request tag table (pending_request_tag_table_top).
// Depends on ptt_pkg and the ptt_req_if / ptt_rsp_if channel interfaces from the RTL.
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS = 64;

    // Time to let pass once the last result is in: long enough for the slowest request,
    // a full sweep, plus a little margin.
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
    // Bound on waiting for outstanding results before they count as lost.
    localparam int DRAIN_LIMIT = 50000;
    // Highest opcode value the field can carry; everything above sweep is ignored.
    localparam int OP_TOP = (1 << ptt_pkg::OP_W) - 1;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [ptt_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ptt_pkg::CFG_DATA_W-1:0] cfg_data;

    ptt_req_if req_ch ();
    ptt_rsp_if rsp_ch ();

    pending_request_tag_table_top #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // -------------------------------------------------------------------------
    // Shadow copy of the table. It is updated at the clock edge where a request
    // is accepted, and every result the request will cause is queued right then.
    // -------------------------------------------------------------------------
    logic                          slot_busy     [SLOTS];
    logic [ptt_pkg::ID_W-1:0]      entry_id      [SLOTS];
    logic [ptt_pkg::CLI_W-1:0]     entry_client  [SLOTS];
    logic [ptt_pkg::TIME_W-1:0]    entry_stamp   [SLOTS];
    logic [ptt_pkg::RETRY_W-1:0]   entry_retries [SLOTS];
    logic [ptt_pkg::TIME_W-1:0]    seconds_count;
    int                            alloc_ptr;
    logic [ptt_pkg::TIMEOUT_W-1:0] timeout_cfg;
    logic [ptt_pkg::RETRY_W-1:0]   retry_limit_cfg;

    ptt_pkg::result_t predicted_results[$];
    ptt_pkg::result_t oldest_result;

    int  mismatches = 0;
    int  requests_sent = 0;
    int  results_checked = 0;
    int  settings_applied = 0;
    // Random idling on both channels; cleared for a long stretch of back-to-back traffic.
    bit  idle_on = 1'b1;

    task automatic reset_shadow_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i]     = 1'b0;
            entry_id[i]      = '0;
            entry_client[i]  = '0;
            entry_stamp[i]   = '0;
            entry_retries[i] = '0;
        end
        seconds_count   = '0;
        alloc_ptr       = 0;
        timeout_cfg     = ptt_pkg::TIMEOUT_RESET;
        retry_limit_cfg = ptt_pkg::RETRY_RESET;
    endtask

    // Appends one expected result at the tail of the prediction queue.
    task automatic queue_result(input ptt_pkg::result_t r);
        predicted_results.insert(predicted_results.size(), r);
    endtask

    // Works out what one accepted request does to the table and which results it causes.
    task automatic predict_table_update(input logic [ptt_pkg::OP_W-1:0] op,
                                        input logic [ptt_pkg::ID_W-1:0] rid,
                                        input logic [ptt_pkg::CLI_W-1:0] cli,
                                        input logic [ptt_pkg::TAG_W-1:0] tag);
        ptt_pkg::result_t           res;
        int                         slot;
        int                         due_count;
        bit                         found;
        logic [ptt_pkg::TIME_W-1:0] age;

        res = '0;
        found = 1'b0;
        due_count = 0;
        case (op)
            ptt_pkg::OP_ADD:
            begin
                // First free slot at or after the rotating pointer wins.
                for (int i = 0; i < SLOTS; i++)
                begin
                    slot = (alloc_ptr + i) % SLOTS;
                    if (!found && !slot_busy[slot])
                    begin
                        found               = 1'b1;
                        slot_busy[slot]     = 1'b1;
                        entry_id[slot]      = rid;
                        entry_client[slot]  = cli;
                        entry_stamp[slot]   = seconds_count;
                        entry_retries[slot] = '0;
                        alloc_ptr           = (slot + 1) % SLOTS;
                        res.status          = ptt_pkg::ST_ADDED;
                        res.tag             = ptt_pkg::TAG_W'(slot);
                        res.request_id      = rid;
                        res.client          = cli;
                    end
                end
                // A full table leaves the pointer where it was and reports zero fields.
                if (!found)
                    res.status = ptt_pkg::ST_FULL;
                res.last = 1'b1;
                queue_result(res);
            end
            ptt_pkg::OP_POP:
            begin
                res.tag = tag;
                if (int'(tag) < SLOTS && slot_busy[tag])
                begin
                    res.status     = ptt_pkg::ST_POPPED;
                    res.request_id = entry_id[tag];
                    res.client     = entry_client[tag];
                    res.retries    = entry_retries[tag];
                    slot_busy[tag] = 1'b0;
                end
                else
                begin
                    res.status = ptt_pkg::ST_MISSING;
                end
                res.last = 1'b1;
                queue_result(res);
            end
            ptt_pkg::OP_ERASE:
            begin
                if (int'(tag) < SLOTS)
                    slot_busy[tag] = 1'b0;
            end
            ptt_pkg::OP_TICK:
            begin
                seconds_count = seconds_count + 1'b1;
            end
            ptt_pkg::OP_SWEEP:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    // The age is taken modulo 2^32 so that a wrapped clock still works.
                    age = seconds_count - entry_stamp[i];
                    if (slot_busy[i] && age >= ptt_pkg::TIME_W'(timeout_cfg))
                    begin
                        res            = '0;
                        res.tag        = ptt_pkg::TAG_W'(i);
                        res.request_id = entry_id[i];
                        res.client     = entry_client[i];
                        if (entry_retries[i] < retry_limit_cfg)
                        begin
                            entry_retries[i] = entry_retries[i] + 1'b1;
                            entry_stamp[i]   = seconds_count;
                            res.status       = ptt_pkg::ST_RETRY;
                        end
                        else
                        begin
                            slot_busy[i] = 1'b0;
                            res.status   = ptt_pkg::ST_EXPIRED;
                        end
                        res.retries = entry_retries[i];
                        queue_result(res);
                        due_count++;
                    end
                end
                if (due_count == 0)
                begin
                    res        = '0;
                    res.status = ptt_pkg::ST_NONE;
                    queue_result(res);
                end
                // Only the final result of the walk carries the last flag.
                res = predicted_results.pop_back();
                res.last = 1'b1;
                queue_result(res);
            end
            default:
            begin
                // Unused opcodes leave the table alone and give no result.
            end
        endcase
    endtask

    // -------------------------------------------------------------------------
    // Request side. Everything is driven with nonblocking assignments at the
    // rising edge and ready is sampled right after the edge, so the values seen
    // are the ones the block saw. Valid stays high from one request straight into
    // the next unless an idle cycle is drawn.
    // -------------------------------------------------------------------------
    task automatic send_request(input logic [ptt_pkg::OP_W-1:0] op,
                                input logic [ptt_pkg::ID_W-1:0] rid,
                                input logic [ptt_pkg::CLI_W-1:0] cli,
                                input logic [ptt_pkg::TAG_W-1:0] tag);
        while (idle_on && $urandom_range(0, 99) < 20)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= op;
        req_ch.request_id    <= rid;
        req_ch.client_handle <= cli;
        req_ch.slot_tag      <= tag;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_table_update(op, rid, cli, tag);
        requests_sent++;
    endtask

    // Sends a request with random content in the fields the opcode does not use.
    task automatic send_op(input logic [ptt_pkg::OP_W-1:0] op,
                           input logic [ptt_pkg::TAG_W-1:0] tag);
        send_request(op, ptt_pkg::ID_W'($urandom), ptt_pkg::CLI_W'($urandom), tag);
    endtask

    // Returns a tag that is currently in use most of the time, else any tag.
    function automatic logic [ptt_pkg::TAG_W-1:0] pick_tag(input int busy_pct);
        int busy_list[$];
        for (int i = 0; i < SLOTS; i++)
            if (slot_busy[i])
                busy_list.insert(busy_list.size(), i);
        if (busy_list.size() > 0 && $urandom_range(0, 99) < busy_pct)
            return ptt_pkg::TAG_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
        return ptt_pkg::TAG_W'($urandom);
    endfunction

    // Stops sending, waits for every queued result, then lets the block settle so
    // that a trailing erase or tick has certainly finished.
    task automatic wait_idle();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        while (predicted_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (predicted_results.size() != 0)
        begin
            $error("%0d expected results never arrived", predicted_results.size());
            mismatches++;
            predicted_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the timeout register, then the retry limit; only call while the block is idle.
    task automatic set_config(input logic [ptt_pkg::TIMEOUT_W-1:0] timeout,
                              input logic [ptt_pkg::RETRY_W-1:0] retry_limit);
        cfg_we    <= 1'b1;
        cfg_index <= ptt_pkg::CFG_TIMEOUT;
        cfg_data  <= ptt_pkg::CFG_DATA_W'(timeout);
        @(posedge clk);
        timeout_cfg = timeout;
        cfg_index <= ptt_pkg::CFG_RETRY;
        cfg_data  <= ptt_pkg::CFG_DATA_W'(retry_limit);
        @(posedge clk);
        retry_limit_cfg = retry_limit;
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // -------------------------------------------------------------------------
    // Result side: ready is drawn at random each cycle while idling is on, and every accepted
    // result is checked field by field against the oldest prediction.
    // -------------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("unexpected result: status %0d tag %0d", rsp_ch.status, rsp_ch.tag_out);
                mismatches++;
            end
            else
            begin
                oldest_result = predicted_results.pop_front();
                if (rsp_ch.status !== oldest_result.status)
                begin
                    $error("status: expected %0d, actual %0d", oldest_result.status,
                           rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.tag_out !== oldest_result.tag)
                begin
                    $error("tag_out: expected %0d, actual %0d", oldest_result.tag,
                           rsp_ch.tag_out);
                    mismatches++;
                end
                if (rsp_ch.request_id_out !== oldest_result.request_id)
                begin
                    $error("request_id_out: expected %h, actual %h", oldest_result.request_id,
                           rsp_ch.request_id_out);
                    mismatches++;
                end
                if (rsp_ch.client_handle_out !== oldest_result.client)
                begin
                    $error("client_handle_out: expected %h, actual %h", oldest_result.client,
                           rsp_ch.client_handle_out);
                    mismatches++;
                end
                if (rsp_ch.retries_out !== oldest_result.retries)
                begin
                    $error("retries_out: expected %0d, actual %0d", oldest_result.retries,
                           rsp_ch.retries_out);
                    mismatches++;
                end
                if (rsp_ch.last !== oldest_result.last)
                begin
                    $error("last: expected %0d, actual %0d", oldest_result.last, rsp_ch.last);
                    mismatches++;
                end
            end
            results_checked++;
        end
    end

    // -------------------------------------------------------------------------
    // Tests
    // -------------------------------------------------------------------------

    // Runs on the reset values of the registers. Covers add with all-zero and
    // all-one fields, pop of a live and of a free tag, erase of a live and of an
    // already free tag, the three unused opcodes, and a sweep with nothing due.
    task automatic test_basic_ops();
        send_request(ptt_pkg::OP_ADD, '0, '0, ptt_pkg::TAG_W'($urandom));
        send_request(ptt_pkg::OP_ADD, '1, '1, ptt_pkg::TAG_W'($urandom));
        send_op(ptt_pkg::OP_ADD, ptt_pkg::TAG_W'($urandom));
        send_op(ptt_pkg::OP_POP, ptt_pkg::TAG_W'(1));
        send_op(ptt_pkg::OP_POP, '1);
        send_op(ptt_pkg::OP_ERASE, '0);
        send_op(ptt_pkg::OP_ERASE, '0);
        send_op(ptt_pkg::OP_POP, '0);
        for (int op = ptt_pkg::OP_SWEEP + 1; op <= OP_TOP; op++)
            send_op(ptt_pkg::OP_W'(op), ptt_pkg::TAG_W'($urandom));
        send_op(ptt_pkg::OP_SWEEP, '0);
    endtask

    // Ages the surviving entry past the default timeout so it is retried, then
    // switches to a zero timeout with no retries, where every live entry is due
    // at once and expires on the next sweep.
    task automatic test_sweep_aging();
        repeat (ptt_pkg::TIMEOUT_RESET) send_op(ptt_pkg::OP_TICK, ptt_pkg::TAG_W'($urandom));
        send_op(ptt_pkg::OP_SWEEP, ptt_pkg::TAG_W'($urandom));
        wait_idle();
        set_config('0, '0);
        send_op(ptt_pkg::OP_ADD, ptt_pkg::TAG_W'($urandom));
        send_op(ptt_pkg::OP_SWEEP, ptt_pkg::TAG_W'($urandom));
    endtask

    // Fills every slot back to back with no idling, checks that one more add is
    // refused, frees a slot and takes it again, then a sweep retries all 64
    // entries, a second sweep finds nothing due, and with no retries left the
    // last sweep expires the whole table.
    task automatic test_full_table();
        wait_idle();
        set_config(ptt_pkg::TIMEOUT_W'(1), '1);
        idle_on = 1'b0;
        repeat (SLOTS) send_op(ptt_pkg::OP_ADD, ptt_pkg::TAG_W'($urandom));
        send_op(ptt_pkg::OP_ADD, ptt_pkg::TAG_W'($urandom));
        send_op(ptt_pkg::OP_POP, pick_tag(100));
        send_op(ptt_pkg::OP_ADD, ptt_pkg::TAG_W'($urandom));
        send_op(ptt_pkg::OP_TICK, ptt_pkg::TAG_W'($urandom));
        send_op(ptt_pkg::OP_SWEEP, ptt_pkg::TAG_W'($urandom));
        send_op(ptt_pkg::OP_SWEEP, ptt_pkg::TAG_W'($urandom));
        wait_idle();
        set_config(ptt_pkg::TIMEOUT_W'(1), '0);
        send_op(ptt_pkg::OP_TICK, ptt_pkg::TAG_W'($urandom));
        send_op(ptt_pkg::OP_SWEEP, ptt_pkg::TAG_W'($urandom));
        idle_on = 1'b1;
    endtask

    // Mixed random traffic over several register settings, from the longest
    // timeout with the most retries down to short ones. Pops and erases mostly
    // aim at live tags so that entries are returned with real content.
    task automatic test_random_traffic();
        int pick;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0: set_config('1, '1);
                1: set_config(ptt_pkg::TIMEOUT_W'($urandom_range(1, 8)),
                              ptt_pkg::RETRY_W'($urandom));
                2: set_config(ptt_pkg::TIMEOUT_W'(2), ptt_pkg::RETRY_W'(3));
                default: set_config(ptt_pkg::TIMEOUT_RESET, ptt_pkg::RETRY_RESET);
            endcase
            for (int n = 0; n < 32; n++)
            begin
                // Halfway through one phase the sender holds off until the table has
                // answered everything, then resumes.
                if (phase == 1 && n == 16)
                    wait_idle();
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    send_op(ptt_pkg::OP_ADD, ptt_pkg::TAG_W'($urandom));
                else if (pick < 50)
                    send_op(ptt_pkg::OP_POP, pick_tag(75));
                else if (pick < 60)
                    send_op(ptt_pkg::OP_ERASE, pick_tag(75));
                else if (pick < 80)
                    send_op(ptt_pkg::OP_TICK, ptt_pkg::TAG_W'($urandom));
                else if (pick < 95)
                    send_op(ptt_pkg::OP_SWEEP, ptt_pkg::TAG_W'($urandom));
                else
                    send_op(ptt_pkg::OP_W'($urandom_range(ptt_pkg::OP_SWEEP + 1, OP_TOP)),
                            ptt_pkg::TAG_W'($urandom));
            end
        end
    endtask

    // Reset once, then the tests in turn, then drain and report.
    initial
    begin
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.opcode        <= ptt_pkg::OP_TICK;
        req_ch.request_id    <= '0;
        req_ch.client_handle <= '0;
        req_ch.slot_tag      <= '0;
        cfg_we               <= 1'b0;
        cfg_index            <= ptt_pkg::CFG_TIMEOUT;
        cfg_data             <= '0;
        reset_shadow_table();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_sweep_aging();
        test_full_table();
        test_random_traffic();
        wait_idle();

        $display("Ran %0d requests with %0d results checked over %0d register settings.",
                 requests_sent, results_checked, settings_applied);
        $display("Covered all opcodes, a full table, zero and maximal timeouts, retry and expiry.");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: a correct run finishes far earlier than this.
    initial
    begin
        #12_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
